### hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared constants and types for the stable priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int SPQ_CAPACITY      = 16;
  localparam int SPQ_PRIORITY_BITS = 8;
  localparam int SPQ_TAG_BITS      = 8;

  // operation code carried on the mode field
  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } spq_mode_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_op_t;

endpackage

### hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds an entry, shifts left or right
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int PRIORITY_BITS = spq_pkg::SPQ_PRIORITY_BITS,
  parameter int TAG_BITS      = spq_pkg::SPQ_TAG_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  spq_pkg::spq_op_t         op,
  input  logic [PRIORITY_BITS-1:0] new_prio,
  input  logic [TAG_BITS-1:0]      new_tag,
  input  logic                     left_valid,
  input  logic [PRIORITY_BITS-1:0] left_prio,
  input  logic [TAG_BITS-1:0]      left_tag,
  input  logic                     left_ge,
  input  logic                     right_valid,
  input  logic [PRIORITY_BITS-1:0] right_prio,
  input  logic [TAG_BITS-1:0]      right_tag,
  output logic                     valid,
  output logic [PRIORITY_BITS-1:0] prio,
  output logic [TAG_BITS-1:0]      tag,
  output logic                     ge
);
  import spq_pkg::*;

  logic                     valid_r, valid_nxt;
  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;
  logic [TAG_BITS-1:0]      tag_r, tag_nxt;

  // entry stays ahead of the new one when equal or higher
  assign ge = valid_r && (prio_r >= new_prio);

  always_comb begin
    valid_nxt = valid_r;
    prio_nxt  = prio_r;
    tag_nxt   = tag_r;
    if (op.deq) begin
      valid_nxt = right_valid;
      prio_nxt  = right_prio;
      tag_nxt   = right_tag;
    end else if (op.enq && !ge) begin
      if (left_ge) begin
        valid_nxt = 1'b1;
        prio_nxt  = new_prio;
        tag_nxt   = new_tag;
      end else begin
        valid_nxt = left_valid;
        prio_nxt  = left_prio;
        tag_nxt   = left_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    tag_r  <= tag_nxt;
  end

  assign valid = valid_r;
  assign prio  = prio_r;
  assign tag   = tag_r;

endmodule

### hw/rtl/stable_priority_queue.sv
// result: registered, presented in the cycle after the input beat is taken
// throughput: one item per cycle while the result side keeps taking beats
// every slot updates in parallel from its own compare and its neighbors
// reset: synchronous active low, queue comes up empty, payload slots undefined
// ----------------------------------------------------------------------------
// stable_priority_queue
// bounded priority queue kept sorted in a chain of cells; equal priorities
// leave in arrival order; each beat reports dequeued entry, drop flag, head and count
// ----------------------------------------------------------------------------
module stable_priority_queue #(
  parameter int CAPACITY      = spq_pkg::SPQ_CAPACITY,
  parameter int PRIORITY_BITS = spq_pkg::SPQ_PRIORITY_BITS,
  parameter int TAG_BITS      = spq_pkg::SPQ_TAG_BITS,
  parameter int CNT_W         = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_mode,
  input  logic [PRIORITY_BITS-1:0] in_entry_priority,
  input  logic [TAG_BITS-1:0]      in_entry_tag,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_dequeue_valid,
  output logic [TAG_BITS-1:0]      out_tag,
  output logic [PRIORITY_BITS-1:0] out_priority,
  output logic                     out_enqueue_dropped,
  output logic                     out_head_valid,
  output logic [TAG_BITS-1:0]      out_head_tag,
  output logic [PRIORITY_BITS-1:0] out_head_priority,
  output logic [CNT_W-1:0]         out_entry_count
);
  import spq_pkg::*;

  // cell chain taps, slot 0 is the head
  logic [CAPACITY-1:0]      cell_valid;
  logic [CAPACITY-1:0]      cell_ge;
  logic [PRIORITY_BITS-1:0] cell_prio [CAPACITY];
  logic [TAG_BITS-1:0]      cell_tag  [CAPACITY];

  // result register and entry counter
  logic                     out_valid_r, out_valid_nxt;
  logic                     deq_valid_r, deq_valid_nxt;
  logic [TAG_BITS-1:0]      deq_tag_r, deq_tag_nxt;
  logic [PRIORITY_BITS-1:0] deq_prio_r, deq_prio_nxt;
  logic                     dropped_r, dropped_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;

  logic    accept;
  logic    is_deq;
  logic    full;
  logic    empty;
  spq_op_t op;

  // a new beat is taken once the previous result has gone or is going now;
  // the chain only moves on an accepted beat so head and count stay put
  // while a result waits
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_deq   = (spq_mode_t'(in_mode) == MODE_DEQ);
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);

  // full enqueue and empty dequeue leave the chain untouched
  assign op.enq = accept && !is_deq && !full;
  assign op.deq = accept && is_deq && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     lv, lg, rv;
    logic [PRIORITY_BITS-1:0] lp, rp;
    logic [TAG_BITS-1:0]      lt, rt;

    // head has nothing ahead of it, so a new entry can land here directly
    if (i == 0) begin : g_head
      assign lv = 1'b0;
      assign lp = '0;
      assign lt = '0;
      assign lg = 1'b1;
    end else begin : g_mid
      assign lv = cell_valid[i-1];
      assign lp = cell_prio[i-1];
      assign lt = cell_tag[i-1];
      assign lg = cell_ge[i-1];
    end

    // tail takes an empty slot on dequeue
    if (i == CAPACITY - 1) begin : g_tail
      assign rv = 1'b0;
      assign rp = '0;
      assign rt = '0;
    end else begin : g_body
      assign rv = cell_valid[i+1];
      assign rp = cell_prio[i+1];
      assign rt = cell_tag[i+1];
    end

    spq_cell #(
      .PRIORITY_BITS (PRIORITY_BITS),
      .TAG_BITS      (TAG_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .op          (op),
      .new_prio    (in_entry_priority),
      .new_tag     (in_entry_tag),
      .left_valid  (lv),
      .left_prio   (lp),
      .left_tag    (lt),
      .left_ge     (lg),
      .right_valid (rv),
      .right_prio  (rp),
      .right_tag   (rt),
      .valid       (cell_valid[i]),
      .prio        (cell_prio[i]),
      .tag         (cell_tag[i]),
      .ge          (cell_ge[i])
    );
  end

  // result and count next state
  always_comb begin
    out_valid_nxt = out_valid_r;
    deq_valid_nxt = deq_valid_r;
    deq_tag_nxt   = deq_tag_r;
    deq_prio_nxt  = deq_prio_r;
    dropped_nxt   = dropped_r;
    count_nxt     = count_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      deq_valid_nxt = op.deq;
      deq_tag_nxt   = op.deq ? cell_tag[0] : '0;
      deq_prio_nxt  = op.deq ? cell_prio[0] : '0;
      dropped_nxt   = !is_deq && full;
      if (op.enq) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (op.deq) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    deq_valid_r <= deq_valid_nxt;
    deq_tag_r   <= deq_tag_nxt;
    deq_prio_r  <= deq_prio_nxt;
    dropped_r   <= dropped_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_dequeue_valid   = deq_valid_r;
  assign out_tag             = deq_tag_r;
  assign out_priority        = deq_prio_r;
  assign out_enqueue_dropped = dropped_r;
  // head comes straight off the chain and count off the counter, both already updated by the beat
  assign out_head_valid      = cell_valid[0];
  assign out_head_tag        = cell_valid[0] ? cell_tag[0] : '0;
  assign out_head_priority   = cell_valid[0] ? cell_prio[0] : '0;
  assign out_entry_count     = count_r;

`ifndef SYNTH
  // counter agrees with the occupied cells
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(count_r))
    else $error("entry count disagrees with occupied cells");

  // occupied cells form an unbroken run from the head
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid & (cell_valid + CAPACITY'(1))) == '0)
    else $error("hole in the cell chain");

  // an enqueue into a full queue is reported as dropped and leaves count
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_deq && full) |=> (out_enqueue_dropped && full))
    else $error("enqueue into full queue not dropped");
`endif

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stable_priority_queue. A sorted shadow copy of the
// queue predicts every result beat: dequeued entry, head, count and the drop
// flag. Ties, empty and full cases and random traffic with stalls are covered.
// ----------------------------------------------------------------------------
module tb;
  import spq_pkg::*;

  localparam int CNT_W       = $clog2(SPQ_CAPACITY + 1);
  localparam int ITEM_GOAL   = 800;  // input beats to offer in total
  localparam int QUIET_ITEMS = 150;  // tail of the run with no idling at all
  localparam int HOLD_CYCLES = 80;   // long result-side hold-off

  typedef logic [SPQ_PRIORITY_BITS-1:0] prio_t;
  typedef logic [SPQ_TAG_BITS-1:0]      tag_t;

  // everything one result beat carries
  typedef struct {
    logic             deq_valid;
    tag_t             deq_tag;
    prio_t            deq_prio;
    logic             dropped;
    logic             head_valid;
    tag_t             head_tag;
    prio_t            head_prio;
    logic [CNT_W-1:0] count;
  } queue_status_t;

  // shadow of the sorted queue plus the beats it still owes us
  class queue_tracker;
    prio_t         slot_prio[SPQ_CAPACITY];
    tag_t          slot_tag[SPQ_CAPACITY];
    int            held;
    queue_status_t owed_status[$];
    int            errors;
    int            checked;
    int            drops;
    int            empty_deqs;
    int            deepest;

    task report(string msg);
      errors++;
      if (errors <= 40) $display("tb: mismatch at %0t ns: %s", $time, msg);
    endtask

    // apply one accepted op to the shadow and queue up its result
    function void note_op(spq_mode_t mode, prio_t prio, tag_t tag);
      queue_status_t s;
      int            pos;
      int            i;
      s = '{default: '0};
      if (mode == MODE_ENQ) begin
        if (held >= SPQ_CAPACITY) begin
          s.dropped = 1'b1;
          drops++;
        end else begin
          // new entry goes behind everything of equal or higher priority
          pos = 0;
          while (pos < held && slot_prio[pos] >= prio) pos++;
          for (i = held; i > pos; i--) begin
            slot_prio[i] = slot_prio[i-1];
            slot_tag[i]  = slot_tag[i-1];
          end
          slot_prio[pos] = prio;
          slot_tag[pos]  = tag;
          held++;
        end
      end else if (held > 0) begin
        s.deq_valid = 1'b1;
        s.deq_tag   = slot_tag[0];
        s.deq_prio  = slot_prio[0];
        for (i = 1; i < held; i++) begin
          slot_prio[i-1] = slot_prio[i];
          slot_tag[i-1]  = slot_tag[i];
        end
        held--;
      end else begin
        empty_deqs++;
      end
      if (held > 0) begin
        s.head_valid = 1'b1;
        s.head_tag   = slot_tag[0];
        s.head_prio  = slot_prio[0];
      end
      s.count = CNT_W'(held);
      if (held > deepest) deepest = held;
      owed_status.push_back(s);
    endfunction

    task check_status(queue_status_t got);
      queue_status_t want;
      if (owed_status.size() == 0) begin
        report("result beat with nothing outstanding");
        return;
      end
      want = owed_status.pop_front();
      checked++;
      if (got.deq_valid !== want.deq_valid)
        report($sformatf("dequeue_valid %b, want %b", got.deq_valid, want.deq_valid));
      if (got.deq_tag !== want.deq_tag)
        report($sformatf("out_tag %h, want %h", got.deq_tag, want.deq_tag));
      if (got.deq_prio !== want.deq_prio)
        report($sformatf("out_priority %h, want %h", got.deq_prio, want.deq_prio));
      if (got.dropped !== want.dropped)
        report($sformatf("enqueue_dropped %b, want %b", got.dropped, want.dropped));
      if (got.head_valid !== want.head_valid)
        report($sformatf("head_valid %b, want %b", got.head_valid, want.head_valid));
      if (got.head_tag !== want.head_tag)
        report($sformatf("head_tag %h, want %h", got.head_tag, want.head_tag));
      if (got.head_prio !== want.head_prio)
        report($sformatf("head_priority %h, want %h", got.head_prio, want.head_prio));
      if (got.count !== want.count)
        report($sformatf("entry_count %0d, want %0d", got.count, want.count));
    endtask

    function int pending();
      return owed_status.size();
    endfunction

    task close_out();
      if (owed_status.size() != 0)
        report($sformatf("%0d result beats never arrived", owed_status.size()));
    endtask
  endclass

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // block ports, all known from time zero
  logic             in_valid          = 1'b0;
  logic             in_ready;
  logic             in_mode           = 1'b0;
  prio_t            in_entry_priority = '0;
  tag_t             in_entry_tag      = '0;
  logic             out_valid;
  logic             out_ready         = 1'b0;
  logic             out_dequeue_valid;
  tag_t             out_tag;
  prio_t            out_priority;
  logic             out_enqueue_dropped;
  logic             out_head_valid;
  tag_t             out_head_tag;
  prio_t            out_head_priority;
  logic [CNT_W-1:0] out_entry_count;

  stable_priority_queue u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_entry_priority   (in_entry_priority),
    .in_entry_tag        (in_entry_tag),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_dequeue_valid   (out_dequeue_valid),
    .out_tag             (out_tag),
    .out_priority        (out_priority),
    .out_enqueue_dropped (out_enqueue_dropped),
    .out_head_valid      (out_head_valid),
    .out_head_tag        (out_head_tag),
    .out_head_priority   (out_head_priority),
    .out_entry_count     (out_entry_count)
  );

  queue_tracker tracker = new();

  // sender and receiver coordination
  bit hold_off_req = 1'b0;  // ask the receiver for one long hold-off
  bit quiet        = 1'b0;  // tail of the run: no idling on either side
  int sent_count   = 0;

  // ---------------------------------------------------------------------------
  // monitor: everything sampled at the rising edge, before any update lands.
  // the input beat is noted first so a zero-latency result would still find
  // its expectation; with a registered result the older one is at the front.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    queue_status_t got;
    if (rst_n) begin
      if (in_valid && in_ready)
        tracker.note_op(spq_mode_t'(in_mode), in_entry_priority, in_entry_tag);
      if (out_valid && out_ready) begin
        got.deq_valid  = out_dequeue_valid;
        got.deq_tag    = out_tag;
        got.deq_prio   = out_priority;
        got.dropped    = out_enqueue_dropped;
        got.head_valid = out_head_valid;
        got.head_tag   = out_head_tag;
        got.head_prio  = out_head_priority;
        got.count      = out_entry_count;
        tracker.check_status(got);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: ready comes in random stretches and random stall bursts, plus
  // one long hold-off on request so the queue backs up and stalls the input
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender tasks
  // ---------------------------------------------------------------------------

  // offer one beat and hold it until the block takes it
  task automatic send_item(input spq_mode_t mode, input prio_t prio, input tag_t tag);
    in_valid          <= 1'b1;
    in_mode           <= mode;
    in_entry_priority <= prio;
    in_entry_tag      <= tag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic idle_for(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // stop offering and wait until every owed result beat is back
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // priorities lean on a few small values so ties are common
  function automatic prio_t pick_priority();
    case ($urandom_range(0, 3))
      0:       return prio_t'($urandom_range(0, 3));
      1:       return $urandom_range(0, 1) ? '1 : '0;
      default: return prio_t'($urandom());
    endcase
  endfunction

  // a run of random ops; enq_pct steers the fill level up, down or level
  task automatic random_run(input int len, input int enq_pct, input bit gaps);
    spq_mode_t mode;
    repeat (len) begin
      mode = ($urandom_range(1, 100) <= enq_pct) ? MODE_ENQ : MODE_DEQ;
      send_item(mode, pick_priority(), tag_t'($urandom()));
      if (gaps && !quiet && $urandom_range(0, 5) == 0)
        idle_for($urandom_range(1, 18));
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // dequeue on an empty queue right out of reset
    send_item(MODE_DEQ, '1, '1);
    // field extremes, then a three-way tie at mid priority and a tie at max
    send_item(MODE_ENQ, '0, '0);
    send_item(MODE_ENQ, '1, '1);
    send_item(MODE_ENQ, 8'h80, 8'h55);
    send_item(MODE_ENQ, 8'h80, 8'hAA);
    send_item(MODE_ENQ, 8'h80, 8'h01);
    send_item(MODE_ENQ, '1, 8'h02);
    send_item(MODE_ENQ, 8'h7F, 8'h7E);
    // drain all seven and one more on the now empty queue
    repeat (8) send_item(MODE_DEQ, prio_t'($urandom()), tag_t'($urandom()));
    wait_drain();

    // result side holds off while we keep offering: fills to capacity,
    // enqueues into the full queue get dropped, then empty it and go past
    hold_off_req = 1'b1;
    repeat (SPQ_CAPACITY + 2) send_item(MODE_ENQ, pick_priority(), tag_t'($urandom()));
    repeat (SPQ_CAPACITY + 2) send_item(MODE_DEQ, prio_t'($urandom()), tag_t'($urandom()));
    // sender pauses until everything owed is back
    wait_drain();

    // random runs that push the fill level up, down or hold it
    while (sent_count < ITEM_GOAL - QUIET_ITEMS) begin
      case ($urandom_range(0, 2))
        0:       random_run($urandom_range(10, 40), 80, $urandom_range(0, 1));
        1:       random_run($urandom_range(10, 40), 25, $urandom_range(0, 1));
        default: random_run($urandom_range(10, 40), 50, $urandom_range(0, 1));
      endcase
      if ($urandom_range(0, 9) == 0) wait_drain();
    end

    // back-to-back tail with no idling anywhere
    quiet = 1'b1;
    while (sent_count < ITEM_GOAL)
      random_run($urandom_range(10, 30), $urandom_range(0, 1) ? 75 : 35, 1'b0);

    wait_drain();
    // spare edges after the drain catch any stray result beat
    repeat (10) @(posedge clk);
    tracker.close_out();

    $display("tb: %0d result beats checked, %0d full-queue drops, %0d empty dequeues",
             tracker.checked, tracker.drops, tracker.empty_deqs);
    $display("tb: deepest fill %0d of %0d, with a %0d-cycle result-side hold-off",
             tracker.deepest, SPQ_CAPACITY, HOLD_CYCLES);
    if (tracker.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
